// ----- sv/bitmap_page_allocator_top_macros.svh -----
// Assertion helpers for the page allocator checker.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, quiet while in reset
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while in reset
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define BPA_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/bpa_pkg.sv -----
`default_nettype none

package bpa_pkg;

    localparam logic [1:0] CMD_ALLOC_ONE   = 2'd0;
    localparam logic [1:0] CMD_FREE_ONE    = 2'd1;
    localparam logic [1:0] CMD_ALLOC_RANGE = 2'd2;
    localparam logic [1:0] CMD_FREE_RANGE  = 2'd3;

    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_NO_SPACE   = 2'd1;
    localparam logic [1:0] STS_ZERO_COUNT = 2'd2;
    localparam logic [1:0] STS_BOUNDS     = 2'd3;

    localparam int          CFG_W             = 13;
    localparam logic [12:0] TOTAL_PAGES_RESET = 13'd4096;
    localparam logic [1:0]  REG_TOTAL_PAGES   = 2'd0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DEC_DONE,
        DEC_SCAN,
        DEC_MARK
    } t_dec;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_SUB,
        UPD_ADD
    } t_upd;

    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic decode;
        logic scan_first;
        logic scan_eval;
        logic mark_read;
        logic mark_write;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        t_dec dec;
        logic found;
        logic scan_last;
        logic mark_skip;
        logic mark_end;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- sv/bpa_ram.sv -----
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/bpa_ctrl.sv -----
`default_nettype none

module bpa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire bpa_pkg::t_dp_sts i_sts,
    output bpa_pkg::t_dp_cmd      o_cmd
);

    bpa_pkg::t_state r_state;
    bpa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            bpa_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = bpa_pkg::S_DECODE;
                end
            end
            bpa_pkg::S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_sts.dec)
                    bpa_pkg::DEC_SCAN: n_state = bpa_pkg::S_SCAN_RD;
                    bpa_pkg::DEC_MARK: n_state = bpa_pkg::S_MARK_RD;
                    default:           n_state = bpa_pkg::S_DONE;
                endcase
            end
            bpa_pkg::S_SCAN_RD: begin
                o_cmd.scan_first = 1'b1;
                n_state          = bpa_pkg::S_SCAN;
            end
            bpa_pkg::S_SCAN: begin
                o_cmd.scan_eval = 1'b1;
                if (i_sts.found) begin
                    n_state = bpa_pkg::S_MARK_RD;
                end else if (i_sts.scan_last) begin
                    n_state = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_MARK_RD: begin
                o_cmd.mark_read = 1'b1;
                if (i_sts.mark_end) begin
                    n_state = bpa_pkg::S_DONE;
                end else if (!i_sts.mark_skip) begin
                    n_state = bpa_pkg::S_MARK_WR;
                end
            end
            bpa_pkg::S_MARK_WR: begin
                o_cmd.mark_write = 1'b1;
                n_state          = bpa_pkg::S_MARK_RD;
            end
            bpa_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = bpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpa_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/bpa_dp.sv -----
`default_nettype none

module bpa_dp #(
    parameter int NUM_PAGES = 4096,
    parameter int WORD_BITS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bpa_pkg::t_dp_cmd i_cmd,
    output bpa_pkg::t_dp_sts      o_sts,
    input  wire logic [12:0]      i_total_pages,
    input  wire logic [1:0]       i_op,
    input  wire logic [11:0]      i_page_index,
    input  wire logic [12:0]      i_page_count,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [11:0]           o_result_page,
    output logic [1:0]            o_status,
    output logic [12:0]           o_free_pages
);

    localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WW        = $clog2(MAP_WORDS + 1);
    localparam int BW        = $clog2(MAP_WORDS * WORD_BITS + 1);
    localparam int PW        = $clog2(NUM_PAGES + 1);
    localparam int CW        = $clog2(WORD_BITS + 1);
    localparam int NB        = $clog2(WORD_BITS) + 1;

    logic [PW-1:0] lim;
    assign lim = (32'(i_total_pages) > 32'(NUM_PAGES)) ? PW'(NUM_PAGES) : PW'(i_total_pages);

    // latched item
    logic [1:0]  r_op;
    logic [11:0] r_idx;
    logic [12:0] r_cnt;

    // working registers
    logic [WW-1:0]    r_word;
    logic [BW-1:0]    r_base;
    logic [PW-1:0]    r_need;
    logic [PW-1:0]    r_len;
    logic [PW-1:0]    r_start;
    logic [WW-1:0]    r_sw;
    logic [BW-1:0]    r_sb;
    logic [PW-1:0]    r_s;
    logic [PW-1:0]    r_e;
    logic             r_set;
    logic [PW-1:0]    r_n;
    bpa_pkg::t_upd    r_upd;
    logic [1:0]       r_status;
    logic [11:0]      r_page;
    logic [PW-1:0]    r_counter;

    logic             r_o_valid;
    logic [11:0]      r_o_page;
    logic [1:0]       r_o_status;
    logic [12:0]      r_o_free;

    // memory
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // decode
    bpa_pkg::t_dec dec_kind;
    logic [1:0]    dec_status;
    bpa_pkg::t_upd dec_upd;
    logic [PW-1:0] dec_n;
    logic [PW-1:0] dec_s;
    logic [PW-1:0] dec_e;
    logic [PW-1:0] dec_need;
    logic          dec_set;
    logic [31:0]   range_end;

    always_comb begin
        dec_kind   = bpa_pkg::DEC_DONE;
        dec_status = bpa_pkg::STS_OK;
        dec_upd    = bpa_pkg::UPD_NONE;
        dec_n      = '0;
        dec_s      = PW'(r_idx);
        dec_e      = PW'(r_idx);
        dec_need   = PW'(1);
        dec_set    = 1'b0;
        range_end  = 32'(r_idx) + 32'(r_cnt);
        case (r_op)
            bpa_pkg::CMD_ALLOC_ONE: begin
                dec_set = 1'b1;
                if (lim == '0) begin
                    dec_status = bpa_pkg::STS_NO_SPACE;
                end else begin
                    dec_kind = bpa_pkg::DEC_SCAN;
                    dec_upd  = bpa_pkg::UPD_SUB;
                    dec_n    = PW'(1);
                end
            end
            bpa_pkg::CMD_ALLOC_RANGE: begin
                dec_set  = 1'b1;
                dec_need = PW'(r_cnt);
                if (r_cnt == '0) begin
                    dec_status = bpa_pkg::STS_ZERO_COUNT;
                end else if (32'(r_cnt) > 32'(lim)) begin
                    dec_status = bpa_pkg::STS_NO_SPACE;
                end else begin
                    dec_kind = bpa_pkg::DEC_SCAN;
                    dec_upd  = bpa_pkg::UPD_SUB;
                    dec_n    = PW'(r_cnt);
                end
            end
            bpa_pkg::CMD_FREE_ONE: begin
                if (32'(r_idx) >= 32'(lim)) begin
                    dec_status = bpa_pkg::STS_BOUNDS;
                end else if (r_idx != '0) begin
                    dec_kind = bpa_pkg::DEC_MARK;
                    dec_upd  = bpa_pkg::UPD_ADD;
                    dec_n    = PW'(1);
                    dec_e    = PW'(32'(r_idx) + 32'd1);
                end
            end
            default: begin
                if (32'(r_idx) >= 32'(lim)) begin
                    dec_status = bpa_pkg::STS_BOUNDS;
                end else begin
                    dec_kind = bpa_pkg::DEC_MARK;
                    dec_upd  = bpa_pkg::UPD_ADD;
                    dec_e    = (range_end > 32'(lim)) ? lim : PW'(range_end);
                    dec_n    = PW'(32'(dec_e) - 32'(r_idx));
                end
            end
        endcase
    end

    // word scan: free bits inside the limit
    logic [WORD_BITS-1:0] free_bits;
    logic [CW-1:0]        tz;
    logic [CW-1:0]        lz;
    logic [WORD_BITS-1:0] acc;
    logic [WORD_BITS-1:0] pw2;
    int                   tot;
    logic [CW-1:0]        pos_b;
    logic                 hit_a;
    logic                 hit_b;
    logic                 found;
    logic [PW-1:0]        found_start;
    logic [WW-1:0]        found_word;
    logic [BW-1:0]        found_base;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            free_bits[j] = ~ram_rdata[j] && ((32'(r_base) + j) < 32'(lim));
        end
        tz = CW'(WORD_BITS);
        lz = CW'(WORD_BITS);
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!free_bits[j]) begin
                tz = CW'(j);
            end
        end
        for (int j = 0; j < WORD_BITS; j++) begin
            if (!free_bits[j]) begin
                lz = CW'(WORD_BITS - 1 - j);
            end
        end
        acc = '1;
        pw2 = free_bits;
        tot = 0;
        for (int b = 0; b < NB; b++) begin
            if (r_need[b]) begin
                acc = acc & (pw2 >> tot);
                tot = tot + (1 << b);
            end
            pw2 = pw2 & (pw2 >> (1 << b));
        end
        pos_b = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (acc[j]) begin
                pos_b = CW'(j);
            end
        end
        hit_a = (32'(r_len) + 32'(tz)) >= 32'(r_need);
        hit_b = (32'(r_need) <= 32'(WORD_BITS)) && (acc != '0);
        found = hit_a || hit_b;
        if (hit_a && (r_len != '0)) begin
            found_start = r_start;
            found_word  = r_sw;
            found_base  = r_sb;
        end else if (hit_a) begin
            found_start = PW'(r_base);
            found_word  = r_word;
            found_base  = r_base;
        end else begin
            found_start = PW'(32'(r_base) + 32'(pos_b));
            found_word  = r_word;
            found_base  = r_base;
        end
    end

    // mark pass
    logic [WORD_BITS-1:0] mark_mask;
    logic [WORD_BITS-1:0] mark_data;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            mark_mask[j] = ((32'(r_base) + j) >= 32'(r_s)) && ((32'(r_base) + j) < 32'(r_e));
        end
        mark_data = r_set ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask);
    end

    assign ram_we    = i_cmd.clr_step | i_cmd.mark_write;
    assign ram_waddr = r_word[AW-1:0];
    assign ram_wdata = i_cmd.clr_step ? '1 : mark_data;
    assign ram_raddr = i_cmd.scan_first ? '0 :
                       i_cmd.scan_eval  ? AW'(32'(r_word) + 32'd1) : r_word[AW-1:0];

    // counter update
    logic [PW-1:0] n_counter;
    logic [31:0]   add_sum;

    always_comb begin
        add_sum = 32'(r_counter) + 32'(r_n);
        case (r_upd)
            bpa_pkg::UPD_SUB: n_counter = (r_n > r_counter) ? '0 : r_counter - r_n;
            bpa_pkg::UPD_ADD: n_counter = (add_sum > 32'(lim)) ? lim : PW'(add_sum);
            default:          n_counter = r_counter;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word    <= '0;
            r_base    <= '0;
            r_counter <= '0;
            r_o_valid <= 1'b0;
            r_upd     <= bpa_pkg::UPD_NONE;
        end else begin
            if (i_cmd.clr_step) begin
                r_word <= WW'(32'(r_word) + 32'd1);
            end
            if (i_cmd.decode) begin
                r_word   <= '0;
                r_base   <= '0;
                r_status <= dec_status;
                r_upd    <= dec_upd;
                r_n      <= dec_n;
                r_s      <= dec_s;
                r_e      <= dec_e;
                r_need   <= dec_need;
                r_set    <= dec_set;
                r_page   <= '0;
            end
            if (i_cmd.scan_first) begin
                r_len <= '0;
            end
            if (i_cmd.scan_eval) begin
                if (found) begin
                    r_word <= found_word;
                    r_base <= found_base;
                    r_s    <= found_start;
                    r_e    <= PW'(32'(found_start) + 32'(r_need));
                    r_page <= 12'(found_start);
                end else if (o_sts.scan_last) begin
                    r_status <= bpa_pkg::STS_NO_SPACE;
                    r_upd    <= bpa_pkg::UPD_NONE;
                end else begin
                    r_word <= WW'(32'(r_word) + 32'd1);
                    r_base <= BW'(32'(r_base) + 32'(WORD_BITS));
                    if (&free_bits) begin
                        r_len <= PW'(32'(r_len) + 32'(WORD_BITS));
                        if (r_len == '0) begin
                            r_start <= PW'(r_base);
                            r_sw    <= r_word;
                            r_sb    <= r_base;
                        end
                    end else begin
                        r_len   <= PW'(lz);
                        r_start <= PW'(32'(r_base) + 32'(WORD_BITS) - 32'(lz));
                        r_sw    <= r_word;
                        r_sb    <= r_base;
                    end
                end
            end
            if ((i_cmd.mark_read && o_sts.mark_skip && !o_sts.mark_end) || i_cmd.mark_write) begin
                r_word <= WW'(32'(r_word) + 32'd1);
                r_base <= BW'(32'(r_base) + 32'(WORD_BITS));
            end
            if (i_cmd.finish) begin
                r_counter  <= n_counter;
                r_o_valid  <= 1'b1;
                r_o_page   <= r_page;
                r_o_status <= r_status;
                r_o_free   <= 13'(n_counter);
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_op;
            r_idx <= i_page_index;
            r_cnt <= i_page_count;
        end
    end

    always_comb begin
        o_sts.clr_last  = (32'(r_word) == (MAP_WORDS - 1));
        o_sts.dec       = dec_kind;
        o_sts.found     = found;
        o_sts.scan_last = (32'(r_base) + 32'(WORD_BITS)) >= 32'(lim);
        o_sts.mark_skip = (32'(r_base) + 32'(WORD_BITS)) <= 32'(r_s);
        o_sts.mark_end  = (32'(r_base) >= 32'(r_e)) || (32'(r_word) >= MAP_WORDS);
        o_sts.out_free  = !r_o_valid || i_ready;
    end

    assign o_valid       = r_o_valid;
    assign o_result_page = r_o_page;
    assign o_status      = r_o_status;
    assign o_free_pages  = r_o_free;

endmodule

`default_nettype wire

// ----- sv/bitmap_page_allocator_top.sv -----
// Bitmap first-fit page allocator, one bit per page (1 = allocated).
// Input channel (i_valid/o_ready) carries one command item: i_cmd, i_page_index,
// i_page_count. Output channel (o_valid/i_ready) returns one result item per
// command: o_result_page, o_status, o_free_pages.
// One item is in flight at a time. After the accepting edge the command is
// decoded; rejected commands go straight to the result. Allocations scan the
// bitmap RAM from word 0 until the scan ends in word c, then read and write
// back mark words a..b; a failed scan ends in word c and goes to the result.
// Frees of words a..b walk the bitmap from word 0, then read and write back
// words a..b. The next item is taken once the result is registered; the scan
// over the bitmap RAM, one word per cycle, sets the rate.
// After reset the bitmap RAM is filled with ones (all allocated), one word per
// cycle, with o_ready low; the free counter is 0 and total_pages is 4096.
// Software frees the usable ranges. The result sits in an output register; a
// new item is taken while it waits, and the block holds in its last step until
// the receiver takes the result. The user must see that total_pages is written
// over the APB port (read at address 0) only while idle; the block won't check.
`default_nettype none

module bitmap_page_allocator_top #(
    parameter int NUM_PAGES = 4096,
    parameter int WORD_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [11:0] i_page_index,
    input  wire logic [12:0] i_page_count,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [11:0]      o_result_page,
    output logic [1:0]       o_status,
    output logic [12:0]      o_free_pages
);

    logic [bpa_pkg::CFG_W-1:0] r_total_pages;
    bpa_pkg::t_dp_cmd          dp_cmd;
    bpa_pkg::t_dp_sts          dp_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_pages <= bpa_pkg::TOTAL_PAGES_RESET;
        end else if (psel && penable && pwrite) begin
            r_total_pages <= pwdata[bpa_pkg::CFG_W-1:0];
        end
    end

    assign prdata = (paddr == bpa_pkg::REG_TOTAL_PAGES) ? 32'(r_total_pages) : '0;

    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    bpa_dp #(
        .NUM_PAGES (NUM_PAGES),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_total_pages (r_total_pages),
        .i_op          (i_cmd),
        .i_page_index  (i_page_index),
        .i_page_count  (i_page_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_page (o_result_page),
        .o_status      (o_status),
        .o_free_pages  (o_free_pages)
    );

endmodule

`default_nettype wire

// ----- sv/bpa_checker.sv -----
`default_nettype none
`include "bitmap_page_allocator_top_macros.svh"

module bpa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [11:0] o_result_page,
    input wire logic [1:0]  o_status
);

    `BPA_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n, !o_valid, "result valid right after reset")

    `BPA_ASSERT_NEXT(a_one_in_flight, i_valid && o_ready, !o_ready, "second item taken in flight")

    `BPA_ASSERT_NOW(a_fail_null_page, o_valid && (o_status != bpa_pkg::STS_OK), o_result_page == '0, "failed command returned a page")

    `BPA_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_result_page) && $stable(o_status), "stalled result changed")

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (.*);

`default_nettype wire

// ----- tb/tb_bitmap_page_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tb_bitmap_page_allocator_top;

    localparam int PAGES = 4096;

    typedef struct packed {
        logic [11:0] page;
        logic [1:0]  status;
        logic [12:0] free_pages;
    } t_alloc_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_cmd = bpa_pkg::CMD_ALLOC_ONE;
    logic [11:0] i_page_index = '0;
    logic [12:0] i_page_count = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [11:0] o_result_page;
    logic [1:0]  o_status;
    logic [12:0] o_free_pages;

    bitmap_page_allocator_top i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic        page_used [PAGES];
    logic [12:0] free_cnt;
    logic [12:0] total_pages;
    t_alloc_res  pending_results [$];
    int          errors = 0;

    // sender / receiver pacing
    int burst_left = 1;
    int max_gap = 6;
    int stall_pct = 30;
    int hold_req = 0;
    int hold_left = 0;

    function automatic t_alloc_res alloc_predict(logic [1:0] cmd, logic [11:0] idx,
                                                 logic [12:0] cnt);
        t_alloc_res r;
        int lim, start, len, stop, v;
        bit found;
        lim = (total_pages > PAGES) ? PAGES : int'(total_pages);
        r = '0;
        case (cmd)
            bpa_pkg::CMD_ALLOC_ONE: begin
                r.status = bpa_pkg::STS_NO_SPACE;
                for (int p = 0; p < lim; p++) begin
                    if (!page_used[p]) begin
                        page_used[p] = 1'b1;
                        free_cnt = (free_cnt == 0) ? 13'd0 : free_cnt - 13'd1;
                        r.page = p[11:0];
                        r.status = bpa_pkg::STS_OK;
                        break;
                    end
                end
            end
            bpa_pkg::CMD_FREE_ONE: begin
                if (int'(idx) >= lim) begin
                    r.status = bpa_pkg::STS_BOUNDS;
                end else if (idx != 0) begin
                    page_used[idx] = 1'b0;
                    v = int'(free_cnt) + 1;
                    free_cnt = (v > lim) ? lim[12:0] : v[12:0];
                end
            end
            bpa_pkg::CMD_ALLOC_RANGE: begin
                if (cnt == 0) begin
                    r.status = bpa_pkg::STS_ZERO_COUNT;
                end else begin
                    start = 0;
                    len = 0;
                    found = 0;
                    for (int p = 0; p < lim; p++) begin
                        if (!page_used[p]) begin
                            if (len == 0) start = p;
                            len++;
                            if (len >= int'(cnt)) begin
                                found = 1;
                                break;
                            end
                        end else begin
                            len = 0;
                        end
                    end
                    if (found) begin
                        for (int p = start; p < start + int'(cnt); p++) page_used[p] = 1'b1;
                        free_cnt = (cnt > free_cnt) ? 13'd0 : free_cnt - cnt;
                        r.page = start[11:0];
                    end else begin
                        r.status = bpa_pkg::STS_NO_SPACE;
                    end
                end
            end
            default: begin
                if (int'(idx) >= lim) begin
                    r.status = bpa_pkg::STS_BOUNDS;
                end else begin
                    stop = int'(idx) + int'(cnt);
                    if (stop > lim) stop = lim;
                    for (int p = int'(idx); p < stop; p++) page_used[p] = 1'b0;
                    v = int'(free_cnt) + stop - int'(idx);
                    free_cnt = (v > lim) ? lim[12:0] : v[12:0];
                end
            end
        endcase
        r.free_pages = free_cnt;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_res exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result_page !== exp_r.page) begin
                    $error("result_page exp %0d got %0d", exp_r.page, o_result_page);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, o_status);
                    errors++;
                end
                if (o_free_pages !== exp_r.free_pages) begin
                    $error("free_pages exp %0d got %0d", exp_r.free_pages, o_free_pages);
                    errors++;
                end
            end
        end
        if (i_rst_n && i_valid && o_ready)
            pending_results.push_back(alloc_predict(i_cmd, i_page_index, i_page_count));
    end

    // receiver stall pattern, with long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [11:0] idx,
                            input logic [12:0] cnt);
        int gap;
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_page_index <= idx;
        i_page_count <= cnt;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_total_pages(input logic [12:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bpa_pkg::REG_TOTAL_PAGES;
        pwdata <= {19'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        total_pages = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_cmd(bpa_pkg::CMD_ALLOC_ONE, 12'd0, 13'd0);          // nothing free yet
        send_cmd(bpa_pkg::CMD_FREE_ONE, 12'd0, 13'd0);           // null page
        send_cmd(bpa_pkg::CMD_ALLOC_RANGE, 12'd0, 13'd0);        // zero count
        send_cmd(bpa_pkg::CMD_FREE_RANGE, 12'd0, 13'd0);         // zero count free
        send_cmd(bpa_pkg::CMD_FREE_RANGE, 12'd0, 13'd8191);      // past the end
        send_cmd(bpa_pkg::CMD_ALLOC_RANGE, 12'd0, 13'd4096);
        send_cmd(bpa_pkg::CMD_ALLOC_ONE, 12'd0, 13'd0);
        send_cmd(bpa_pkg::CMD_FREE_ONE, 12'd4095, 13'd0);
        send_cmd(bpa_pkg::CMD_FREE_ONE, 12'd4095, 13'd0);        // double free
        send_cmd(bpa_pkg::CMD_ALLOC_RANGE, 12'd0, 13'd8191);     // longer than limit
        send_cmd(bpa_pkg::CMD_ALLOC_ONE, 12'd0, 13'd0);
        send_cmd(bpa_pkg::CMD_FREE_RANGE, 12'd4032, 13'd64);
        send_cmd(bpa_pkg::CMD_ALLOC_RANGE, 12'd0, 13'd33);
        wait_idle();
        write_total_pages(13'd100);
        send_cmd(bpa_pkg::CMD_FREE_ONE, 12'd100, 13'd0);         // out of bounds
        send_cmd(bpa_pkg::CMD_FREE_RANGE, 12'd4095, 13'd1);      // start out of bounds
        send_cmd(bpa_pkg::CMD_FREE_RANGE, 12'd90, 13'd50);
        send_cmd(bpa_pkg::CMD_ALLOC_RANGE, 12'd0, 13'd11);
        send_cmd(bpa_pkg::CMD_ALLOC_ONE, 12'd0, 13'd0);
        wait_idle();
    endtask

    task automatic random_phase(input logic [12:0] tp, input int n);
        int lim, k, lo;
        logic [11:0] idx;
        logic [12:0] cnt;
        write_total_pages(tp);
        lim = (tp > PAGES) ? PAGES : int'(tp);
        send_cmd(bpa_pkg::CMD_FREE_RANGE, 12'd0, 13'd4096);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            idx = (lim > 0) ? 12'($urandom_range(0, lim - 1)) : 12'($urandom);
            cnt = 13'($urandom_range(1, 16));
            if (k < 35) begin
                if ($urandom_range(0, 9) == 0) cnt = 13'($urandom);
                send_cmd(bpa_pkg::CMD_ALLOC_RANGE, idx, cnt);
            end else if (k < 60) begin
                send_cmd(bpa_pkg::CMD_ALLOC_ONE, idx, cnt);
            end else if (k < 75) begin
                send_cmd(bpa_pkg::CMD_FREE_ONE, idx, cnt);
            end else if (k < 92) begin
                lo = $urandom_range(0, 3);
                if (lo == 0) cnt = 13'($urandom);
                send_cmd(bpa_pkg::CMD_FREE_RANGE, idx, cnt);
            end else begin
                send_cmd(2'($urandom), 12'($urandom), 13'($urandom));
            end
        end
        wait_idle();
    endtask

    task automatic test_random();
        max_gap = 6;
        stall_pct = 30;
        random_phase(13'd4096, 200);
        max_gap = 0;
        stall_pct = 0;
        random_phase(13'd8191, 100);
        max_gap = 10;
        stall_pct = 60;
        random_phase(13'd0, 30);
        random_phase(13'd1, 40);
        max_gap = 3;
        stall_pct = 20;
        random_phase(13'd64, 100);
        random_phase(13'($urandom_range(65, 4095)), 200);
    endtask

    task automatic test_backpressure();
        write_total_pages(13'd4096);
        max_gap = 0;
        stall_pct = 0;
        hold_req = 400;
        for (int i = 0; i < 20; i++)
            send_cmd(bpa_pkg::CMD_FREE_RANGE, 12'($urandom), 13'($urandom_range(0, 8)));
        wait_idle();
        stall_pct = 25;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < PAGES; p++) page_used[p] = 1'b1;
        free_cnt = '0;
        total_pages = bpa_pkg::TOTAL_PAGES_RESET;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        wait_idle();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_ctrl.sv
sv/bpa_dp.sv
sv/bitmap_page_allocator_top.sv
sv/bpa_checker.sv
tb/tb_bitmap_page_allocator_top.sv
